// ===== sv/contour_level_edge_classifier_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the contour level edge classifier
// Each macro states one concurrent property on the clock, with reset
// disabling the check.
// ----------------------------------------------------------------------------
`ifndef CONTOUR_LEVEL_EDGE_CLASSIFIER_ASSERT_SVH
`define CONTOUR_LEVEL_EDGE_CLASSIFIER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define CLEC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CLEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/clec_pkg.sv =====
// ----------------------------------------------------------------------------
// Contour level edge classifier package
// Sizes, value type, register indexes and border flags shared by the design.
// ----------------------------------------------------------------------------
package clec_pkg;

   localparam int MAX_SAMPLES = 1024;
   localparam int MAX_LEVELS  = 5;
   localparam int VALUE_W     = 32;

   localparam int COL_W      = $clog2(MAX_SAMPLES);
   localparam int SAMPLES_W  = 11;
   localparam int ROW_W      = 16;
   localparam int LCOUNT_W   = 3;
   localparam int CODE_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_LINES   = 3'd0,
      REG_FRAME_SAMPLES = 3'd1,
      REG_LEVEL_COUNT   = 3'd2,
      REG_LEVEL_ZERO    = 3'd3,
      REG_LEVEL_ONE     = 3'd4,
      REG_LEVEL_TWO     = 3'd5,
      REG_LEVEL_THREE   = 3'd6,
      REG_LEVEL_FOUR    = 3'd7
   } csr_index_type;

   // Which rows and columns of the 3x3 neighbourhood lie inside the frame.
   typedef struct packed {
      logic [2:0] row_ok;
      logic [2:0] col_ok;
   } border_type;

endpackage

// ===== sv/contour_level_edge_classifier.sv =====
// ----------------------------------------------------------------------------
// Contour level edge classifier
// Classifies a raster stream of Q16.16 arrival times against up to five
// increasing contour levels, using two line buffers and a 3x3 window.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                                   | Direction
//   --------+-----------------------------------------+----------
//   req     | req_valid, req_stall, req_time_value,   | in
//           | req_is_flush                            |
//   rsp     | rsp_valid, rsp_stall, rsp_class_code,   | out
//           | rsp_last_of_frame                       |
//   csr     | csr_write, csr_index, csr_data          | in
//
// One item is taken in every clock cycle while req_stall is low. A result
// leaves the output register after the transfer of the item that produces
// it has passed the line buffer read, the window, the level compare and
// the code encoder stages. Results lag the pixels by one line plus one item.
// Reset is synchronous; the line buffers are not cleared, since their stale
// contents only ever reach neighbours that lie outside the frame.
// A stall on the result channel freezes the whole pipeline, and the input
// is stalled only while a result is held in the output register.
//
`include "contour_level_edge_classifier_assert.svh"

module contour_level_edge_classifier
   import clec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  value_type             req_time_value,
   input  logic                  req_is_flush,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CODE_W-1:0]     rsp_class_code,
   output logic                  rsp_last_of_frame,

   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   logic [ROW_W-1:0]      frame_lines_ff;
   logic [SAMPLES_W-1:0]  frame_samples_ff;
   logic [LCOUNT_W-1:0]   level_count_ff;
   value_type             level_ff [MAX_LEVELS];

   logic                  wr_lines;
   logic                  wr_samples;
   logic                  wr_count;
   logic [MAX_LEVELS-1:0] wr_level;

   // The register index decoder gives one write strobe for each register.
   always_comb begin
      wr_lines   = 1'b0;
      wr_samples = 1'b0;
      wr_count   = 1'b0;
      wr_level   = '0;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            REG_FRAME_LINES:   wr_lines   = 1'b1;
            REG_FRAME_SAMPLES: wr_samples = 1'b1;
            REG_LEVEL_COUNT:   wr_count   = 1'b1;
            REG_LEVEL_ZERO:    wr_level[0] = 1'b1;
            REG_LEVEL_ONE:     wr_level[1] = 1'b1;
            REG_LEVEL_TWO:     wr_level[2] = 1'b1;
            REG_LEVEL_THREE:   wr_level[3] = 1'b1;
            REG_LEVEL_FOUR:    wr_level[4] = 1'b1;
            default: begin
               wr_lines = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_lines_ff   <= ROW_W'(1);
         frame_samples_ff <= SAMPLES_W'(1);
         level_count_ff   <= LCOUNT_W'(1);
         for (int i = 0; i < MAX_LEVELS; i++) begin
            level_ff[i] <= '0;
         end
      end else begin
         if (wr_lines) begin
            frame_lines_ff <= csr_data[ROW_W-1:0];
         end
         if (wr_samples) begin
            frame_samples_ff <= csr_data[SAMPLES_W-1:0];
         end
         if (wr_count) begin
            level_count_ff <= csr_data[LCOUNT_W-1:0];
         end
         for (int i = 0; i < MAX_LEVELS; i++) begin
            if (wr_level[i]) begin
               level_ff[i] <= value_type'(csr_data[VALUE_W-1:0]);
            end
         end
      end
   end

   // Out-of-range register values are clamped to the nearest usable value.
   logic [ROW_W-1:0]     rows_eff;
   logic [SAMPLES_W-1:0] cols_eff;
   logic [LCOUNT_W-1:0]  nlev_eff;

   always_comb begin
      rows_eff = (frame_lines_ff == '0) ? ROW_W'(1) : frame_lines_ff;
      if (frame_samples_ff == '0) begin
         cols_eff = SAMPLES_W'(1);
      end else if (frame_samples_ff > SAMPLES_W'(MAX_SAMPLES)) begin
         cols_eff = SAMPLES_W'(MAX_SAMPLES);
      end else begin
         cols_eff = frame_samples_ff;
      end
      if (level_count_ff == '0) begin
         nlev_eff = LCOUNT_W'(1);
      end else if (level_count_ff > LCOUNT_W'(MAX_LEVELS)) begin
         nlev_eff = LCOUNT_W'(MAX_LEVELS);
      end else begin
         nlev_eff = level_count_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Pipeline advance. Every stage moves together; the pipeline only holds
   // while the output register carries a result that is not being taken.
   // -------------------------------------------------------------------------
   logic rsp_valid_ff;
   logic adv;
   logic acc;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign acc       = req_valid && adv;

   // -------------------------------------------------------------------------
   // Stage A: position counters. All frame bookkeeping is settled here, on
   // the item's transfer, so later stages only carry flags with the data.
   // -------------------------------------------------------------------------
   logic [COL_W-1:0]     in_col_ff;
   logic [COL_W-1:0]     out_col_ff;
   logic [ROW_W-1:0]     out_row_ff;
   logic [SAMPLES_W-1:0] lag_ff;

   logic [COL_W-1:0]     a_col;
   logic [SAMPLES_W-1:0] a_col_inc;
   logic [COL_W-1:0]     a_in_col_next;
   logic [SAMPLES_W:0]   a_lag_limit;
   logic                 a_emit;
   logic [COL_W-1:0]     a_ocol;
   logic [SAMPLES_W-1:0] a_ocol_inc;
   logic [ROW_W:0]       a_orow_inc;
   logic                 a_last;
   border_type           a_border;
   value_type            a_value;

   always_comb begin
      a_col = ({1'b0, in_col_ff} >= cols_eff) ? '0 : in_col_ff;
      a_col_inc = {1'b0, a_col} + SAMPLES_W'(1);
      a_in_col_next = (a_col_inc >= cols_eff) ? '0 : a_col_inc[COL_W-1:0];

      // The first line plus one item only fill the window.
      a_lag_limit = {1'b0, cols_eff} + (SAMPLES_W+1)'(1);
      a_emit = ({1'b0, lag_ff} >= a_lag_limit);

      a_ocol = ({1'b0, out_col_ff} >= cols_eff) ? '0 : out_col_ff;
      a_ocol_inc = {1'b0, a_ocol} + SAMPLES_W'(1);
      a_orow_inc = {1'b0, out_row_ff} + (ROW_W+1)'(1);
      a_last = a_emit && (a_orow_inc >= {1'b0, rows_eff}) && (a_ocol_inc >= cols_eff);

      a_border.row_ok[0] = (out_row_ff != '0) && (out_row_ff <= rows_eff);
      a_border.row_ok[1] = (out_row_ff < rows_eff);
      a_border.row_ok[2] = (a_orow_inc < {1'b0, rows_eff});
      a_border.col_ok[0] = (a_ocol != '0) && ({1'b0, a_ocol} <= cols_eff);
      a_border.col_ok[1] = ({1'b0, a_ocol} < cols_eff);
      a_border.col_ok[2] = (a_ocol_inc < cols_eff);

      // A flush item inside the frame counts as a pixel of value zero.
      a_value = req_is_flush ? '0 : req_time_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lag_ff     <= '0;
      end else if (acc) begin
         if (a_last) begin
            // End of frame: every counter returns to the frame start.
            in_col_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
            lag_ff     <= '0;
         end else begin
            in_col_ff <= a_in_col_next;
            if (!a_emit) begin
               lag_ff <= lag_ff + SAMPLES_W'(1);
            end else if (a_ocol_inc >= cols_eff) begin
               out_col_ff <= '0;
               if (out_row_ff != '1) begin
                  out_row_ff <= out_row_ff + ROW_W'(1);
               end
            end else begin
               out_col_ff <= a_ocol_inc[COL_W-1:0];
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stage 1: line buffer access. Both line buffers share one memory word per
   // column. The read is issued on the transfer and its word is registered;
   // the write happens from this stage. When two consecutive items hit the
   // same column (one pixel per line) the write of the older item is
   // forwarded, since the memory returns the old word on a collision.
   // -------------------------------------------------------------------------
   logic [2*VALUE_W-1:0] line_mem [MAX_SAMPLES];
   logic [2*VALUE_W-1:0] mem_q_ff;

   logic                 s1_valid_ff;
   logic                 s1_fwd_hit_ff;
   logic [2*VALUE_W-1:0] s1_fwd_data_ff;
   value_type            s1_value_ff;
   logic [COL_W-1:0]     s1_col_ff;
   logic                 s1_emit_ff;
   logic                 s1_last_ff;
   border_type           s1_border_ff;

   logic [2*VALUE_W-1:0] s1_rd;
   value_type            s1_up;
   value_type            s1_mid;
   logic [2*VALUE_W-1:0] s1_wr_data;

   always_comb begin
      s1_rd      = s1_fwd_hit_ff ? s1_fwd_data_ff : mem_q_ff;
      s1_up      = value_type'(s1_rd[2*VALUE_W-1:VALUE_W]);
      s1_mid     = value_type'(s1_rd[VALUE_W-1:0]);
      // The middle line moves up and the new pixel takes its place.
      s1_wr_data = {s1_mid, s1_value_ff};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mem_q_ff <= line_mem[a_col];
         if (s1_valid_ff) begin
            line_mem[s1_col_ff] <= s1_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s1_fwd_hit_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff   <= acc;
         s1_fwd_hit_ff <= acc && s1_valid_ff && (s1_col_ff == a_col);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_fwd_data_ff <= s1_wr_data;
         s1_value_ff    <= a_value;
         s1_col_ff      <= a_col;
         s1_emit_ff     <= a_emit;
         s1_last_ff     <= a_last;
         s1_border_ff   <= a_border;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 2: the 3x3 window. Every item shifts one column in; items that
   // produce no result still do so. After the frame's final pixel the window
   // is emptied, which is done lazily: the next shift starts from zeros.
   // Reset sets the same flag, so the window needs no reset of its own.
   // -------------------------------------------------------------------------
   value_type        win_ff [3][3];
   logic             clear_pend_ff;
   logic             s2_valid_ff;
   logic             s2_last_ff;
   logic [2:0][2:0]  s2_mask_ff;

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= clear_pend_ff ? '0 : win_ff[r][1];
            win_ff[r][1] <= clear_pend_ff ? '0 : win_ff[r][2];
         end
         win_ff[0][2] <= s1_up;
         win_ff[1][2] <= s1_mid;
         win_ff[2][2] <= s1_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_pend_ff <= 1'b1;
         s2_valid_ff   <= 1'b0;
      end else if (adv) begin
         if (s1_valid_ff) begin
            clear_pend_ff <= s1_emit_ff && s1_last_ff;
         end
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_last_ff <= s1_last_ff;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               s2_mask_ff[r][c] <= s1_border_ff.row_ok[r] && s1_border_ff.col_ok[c]
                                   && !(r == 1 && c == 1);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stage 3: level compares. For each level the centre pixel is compared
   // once, and each in-frame neighbour is checked for lying below it.
   // -------------------------------------------------------------------------
   logic [MAX_LEVELS-1:0] s2_edge;
   logic [MAX_LEVELS-1:0] s2_below;
   logic [MAX_LEVELS-1:0] s2_nb_below;

   always_comb begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
         s2_nb_below[i] = 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               if (s2_mask_ff[r][c] && (win_ff[r][c] < level_ff[i])) begin
                  s2_nb_below[i] = 1'b1;
               end
            end
         end
         s2_edge[i]  = (win_ff[1][1] == level_ff[i])
                       || ((win_ff[1][1] > level_ff[i]) && s2_nb_below[i]);
         s2_below[i] = (win_ff[1][1] < level_ff[i]);
      end
   end

   logic                  s3_valid_ff;
   logic                  s3_last_ff;
   logic [MAX_LEVELS-1:0] s3_edge_ff;
   logic [MAX_LEVELS-1:0] s3_below_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_last_ff  <= s2_last_ff;
         s3_edge_ff  <= s2_edge;
         s3_below_ff <= s2_below;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 4: code encoder and output register. An edge of the lowest level
   // wins; failing that, the lowest level above the pixel; failing that,
   // the pixel lies above every level in use.
   // -------------------------------------------------------------------------
   logic [CODE_W-1:0] s3_code;
   logic [CODE_W-1:0] rsp_code_ff;
   logic              rsp_last_ff;

   always_comb begin
      s3_code = CODE_W'(2 * nlev_eff);
      for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
         if ((LCOUNT_W'(i) < nlev_eff) && s3_below_ff[i]) begin
            s3_code = CODE_W'(2 * i);
         end
      end
      for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
         if ((LCOUNT_W'(i) < nlev_eff) && s3_edge_ff[i]) begin
            s3_code = CODE_W'(2 * i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_code_ff <= s3_code;
         rsp_last_ff <= s3_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_class_code    = rsp_code_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   logic [CODE_W-1:0] code_limit;
   logic              code_ok;
   logic              a_frame_end;
   logic              counters_idle;

   assign code_limit    = CODE_W'(2 * nlev_eff);
   assign code_ok       = (rsp_code_ff <= code_limit);
   assign a_frame_end   = acc && a_last;
   assign counters_idle = (lag_ff == '0) && (out_row_ff == '0)
                          && (out_col_ff == '0) && (in_col_ff == '0);

   `CLEC_ASSERT_SAME(a_code_in_range, clock, reset, rsp_valid_ff, code_ok, "code out of range")
   `CLEC_ASSERT_SAME(a_fwd_valid, clock, reset, s1_fwd_hit_ff, s1_valid_ff, "stray forward")
   `CLEC_ASSERT_NEXT(a_restart, clock, reset, a_frame_end, counters_idle, "stale counters")

endmodule
